FILE: design/rpd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the RC pulse decoder.
// No dependencies; every other design file imports this package.
package rpd_pkg;

   localparam int TIME_BITS   = 32;
   localparam int CFG_W       = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int US_PER_MS   = 1000;
   localparam int TIMEOUT_US_W = 26;
   localparam int AGE_CMP_W   = (TIME_BITS > TIMEOUT_US_W) ? TIME_BITS : TIMEOUT_US_W;
   localparam int WIDTH_CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
   localparam int Q15_W       = 16;
   localparam int QUOT_W      = 15;
   localparam int DIV_STEPS   = QUOT_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_MIN     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_NEUTRAL = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_MAX     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_TIMEOUT_MS    = 2'd3;

   localparam logic [1:0] CMD_QUERY = 2'd0;
   localparam logic [1:0] CMD_RISE  = 2'd1;
   localparam logic [1:0] CMD_FALL  = 2'd2;

   typedef struct packed {
      logic [CFG_W-1:0]        pulse_min;
      logic [CFG_W-1:0]        pulse_neutral;
      logic [CFG_W-1:0]        pulse_max;
      logic [TIMEOUT_US_W-1:0] timeout_us;
   } cfg_type;

   typedef struct packed {
      logic                 map_en;
      logic                 channel;
      logic [TIME_BITS-1:0] now_us;
      logic [CFG_W-1:0]     width;
   } job_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic             start;
      logic [CFG_W-1:0] num;
      logic [CFG_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_status_type;

   typedef struct packed {
      logic [Q15_W-1:0] throttle_value;
      logic             throttle_valid;
      logic [Q15_W-1:0] steering_value;
      logic             steering_valid;
      logic             both_active;
   } result_type;

endpackage

FILE: design/rpd_front.sv
`timescale 1ns / 1ps
// Front end: accepts edge and query items, keeps the rise stamps and
// classifies each fall. Depends on rpd_pkg.
module rpd_front import rpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_command,
   input  logic             req_channel,
   input  logic [31:0]      req_now_us,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   output logic             q_push,
   output job_type          q_job
);

   logic [TIME_BITS-1:0] rise_stamp_ff [2];
   logic [TIME_BITS-1:0] rise_stamp_in [2];
   logic [1:0]           armed_ff;
   logic [1:0]           armed_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] width_full;
   logic                 in_bounds;
   logic                 is_rise;
   logic                 is_fall;

   always_comb begin
      now_t      = TIME_BITS'(req_now_us);
      req_tready = !q_status.full;
      q_push     = req_tvalid && req_tready;
      is_rise    = (req_command == CMD_RISE);
      is_fall    = (req_command == CMD_FALL);
      width_full = now_t - rise_stamp_ff[req_channel];
      in_bounds  = (WIDTH_CMP_W'(width_full) >= WIDTH_CMP_W'(cfg.pulse_min)) &&
                   (WIDTH_CMP_W'(width_full) <= WIDTH_CMP_W'(cfg.pulse_max));

      q_job.map_en  = is_fall && armed_ff[req_channel] && in_bounds;
      q_job.channel = req_channel;
      q_job.now_us  = now_t;
      q_job.width   = CFG_W'(width_full);

      rise_stamp_in = rise_stamp_ff;
      armed_in      = armed_ff;
      if (q_push && is_rise) begin
         rise_stamp_in[req_channel] = now_t;
         armed_in[req_channel]      = 1'b1;
      end
      // Every fall disarms, whether or not the width is accepted.
      if (q_push && is_fall) begin
         armed_in[req_channel] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      rise_stamp_ff <= rise_stamp_in;
   end

endmodule

FILE: design/rpd_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Depends on rpd_pkg.
module rpd_queue import rpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      head_job     = slot_ff[rd_ptr_ff];
      status.count = count_ff;
      status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/rpd_div.sv
`timescale 1ns / 1ps
// Serial divider for the Q1.15 scaling: round(num * 32767 / den), one
// quotient bit per cycle. Depends on rpd_pkg.
module rpd_div import rpd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  div_req_type    req,
   output div_status_type status
);

   localparam int PROD_W = CFG_W + QUOT_W;

   logic [CFG_W-1:0]     rem_ff;
   logic [CFG_W-1:0]     rem_in;
   logic [QUOT_W-1:0]    low_ff;
   logic [QUOT_W-1:0]    low_in;
   logic [CFG_W-1:0]     dvs_ff;
   logic [CFG_W-1:0]     dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;

   logic [PROD_W-1:0]    prod;
   logic [CFG_W:0]       trial;
   logic                 ge;

   always_comb begin
      // num * 32767 + den / 2; since num <= den the quotient fits in 15 bits,
      // so the upper 16 bits already sit below the divisor.
      prod  = (PROD_W'(req.num) << QUOT_W) - PROD_W'(req.num) +
              PROD_W'(req.den >> 1);
      trial = {rem_ff, low_ff[QUOT_W-1]};
      ge    = (trial >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      low_in  = low_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = prod[PROD_W-1:QUOT_W];
         low_in  = prod[QUOT_W-1:0];
         dvs_in  = req.den;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? CFG_W'(trial - {1'b0, dvs_ff}) : trial[CFG_W-1:0];
         low_in = {low_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      status.busy = busy_ff;
      status.done = done_ff;
      status.quot = low_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
   end

endmodule

FILE: design/rpd_back.sv
`timescale 1ns / 1ps
// Back end: takes jobs from the queue, maps accepted widths to Q1.15,
// keeps positions and pulse stamps and forms each result. Depends on rpd_pkg.
module rpd_back import rpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             q_pop,
   output div_req_type      div_req,
   input  div_status_type   div_status,
   output logic             res_valid,
   input  logic             res_ready,
   output result_type       result
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]           state_ff;
   logic [2:0]           state_in;
   job_type              job_ff;
   job_type              job_in;
   logic [CFG_W-1:0]     num_ff;
   logic [CFG_W-1:0]     num_in;
   logic [CFG_W-1:0]     den_ff;
   logic [CFG_W-1:0]     den_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic [Q15_W-1:0]     value_ff;
   logic [Q15_W-1:0]     value_in;
   logic [Q15_W-1:0]     position_ff [2];
   logic [Q15_W-1:0]     position_in [2];
   logic [TIME_BITS-1:0] pulse_stamp_ff [2];
   logic [TIME_BITS-1:0] pulse_stamp_in [2];

   logic                 upper;
   logic [TIME_BITS-1:0] age [2];
   logic [1:0]           ch_valid;

   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      neg_in         = neg_ff;
      value_in       = value_ff;
      position_in    = position_ff;
      pulse_stamp_in = pulse_stamp_ff;
      q_pop          = 1'b0;
      res_valid      = 1'b0;
      div_req.start  = 1'b0;
      div_req.num    = num_ff;
      div_req.den    = den_ff;
      upper          = (job_ff.width >= cfg.pulse_neutral);

      // The item's own channel sees its new stamp and position at once.
      for (int c = 0; c < 2; c++) begin
         if (job_ff.map_en && (job_ff.channel == 1'(c))) begin
            position_in[c]    = value_ff;
            pulse_stamp_in[c] = job_ff.now_us;
         end
         age[c]      = job_ff.now_us - pulse_stamp_in[c];
         ch_valid[c] = (AGE_CMP_W'(age[c]) < AGE_CMP_W'(cfg.timeout_us));
      end
      result.throttle_value = position_in[0];
      result.throttle_valid = ch_valid[0];
      result.steering_value = position_in[1];
      result.steering_valid = ch_valid[1];
      result.both_active    = ch_valid[0] & ch_valid[1];

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               job_in   = head_job;
               state_in = head_job.map_en ? ST_PREP : ST_FIN;
            end
         end
         ST_PREP: begin
            // Below neutral the accepted width implies min < neutral.
            num_in = upper ? job_ff.width - cfg.pulse_neutral
                           : cfg.pulse_neutral - job_ff.width;
            den_in = upper ? cfg.pulse_max - cfg.pulse_neutral
                           : cfg.pulse_neutral - cfg.pulse_min;
            neg_in = !upper;
            if (den_in == '0) begin
               value_in = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               value_in = neg_ff ? Q15_W'(0) - Q15_W'(div_status.quot)
                                 : Q15_W'(div_status.quot);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Channel state only commits once the result has left.
      if (!(state_ff == ST_FIN && res_ready)) begin
         position_in    = position_ff;
         pulse_stamp_in = pulse_stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         position_ff    <= '{default: '0};
         pulse_stamp_ff <= '{default: '0};
      end else begin
         state_ff       <= state_in;
         position_ff    <= position_in;
         pulse_stamp_ff <= pulse_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
   end

endmodule

FILE: design/rc_pwm_pulse_decoder.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Contents
// req     | in        | req_tvalid/req_tready | edge or query item, one result each
// rsp     | out       | rsp_tvalid/rsp_tready | both positions, valid bits, both_active
// csr     | in        | csr_we                | register writes, no read-back
//
// A query, a rise or a rejected fall goes from IDLE straight to FIN in the back end;
// an accepted pulse passes PREP, START, DIV (the 15-step serial divider in rpd_div)
// and FIN, or just PREP and FIN when the span on its side of neutral is zero.
// Results leave through an output register in the cycle after the back end ends.
// Reset is synchronous; no clearing pass is needed after it.
// A two-entry queue lets the front end take items while the back end or the
// result channel is stalled.
// Top level of the RC pulse decoder; depends on rpd_pkg, rpd_front,
// rpd_queue, rpd_div and rpd_back.
module rc_pwm_pulse_decoder import rpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,  // now_us
   input  logic [2:0]            req_tuser,  // command, channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,  // throttle_value, throttle_valid,
                                             // steering_value, steering_valid,
                                             // both_active, zero fill
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             q_push;
   logic             q_pop;
   div_req_type      div_req;
   div_status_type   div_status;
   logic             res_valid;
   logic             res_ready;
   result_type       result;
   logic             rsp_tvalid_ff;
   logic             rsp_tvalid_in;
   logic [39:0]      rsp_data_ff;
   logic [39:0]      rsp_data_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_PULSE_MIN:     cfg_in.pulse_min     = csr_wdata;
            REG_PULSE_NEUTRAL: cfg_in.pulse_neutral = csr_wdata;
            REG_PULSE_MAX:     cfg_in.pulse_max     = csr_wdata;
            REG_TIMEOUT_MS: begin
               // Keep the timeout in microseconds: age / 1000 < T iff age < 1000 * T.
               cfg_in.timeout_us = TIMEOUT_US_W'(32'(csr_wdata) * 32'(US_PER_MS));
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min     <= CFG_W'(1000);
         cfg_ff.pulse_neutral <= CFG_W'(1500);
         cfg_ff.pulse_max     <= CFG_W'(2000);
         cfg_ff.timeout_us    <= TIMEOUT_US_W'(250 * US_PER_MS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser[1:0]),
      .req_channel (req_tuser[2]),
      .req_now_us  (req_tdata),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   rpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   rpd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .status (div_status)
   );

   rpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_job   (head_job),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_status (div_status),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .result     (result)
   );

   always_comb begin
      res_ready     = !rsp_tvalid_ff || rsp_tready;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = {5'b0, result.both_active, result.steering_valid,
                          result.steering_value, result.throttle_valid,
                          result.throttle_value};
      end
      rsp_tvalid = rsp_tvalid_ff;
      rsp_tdata  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("job queue holds more items than its depth");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back end popped an empty job queue");

   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_status.busy)
      else $error("divider restarted while still busy");

   assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid)
      else $error("back end dropped a finished result before it was taken");

endmodule
